@@ src/lmsnt_pkg.sv @@
package lmsnt_pkg;

    // Field widths fixed by the stream format
    localparam int PAT_W      = 20;
    localparam int RATE_W     = 16;
    localparam int THR_W      = 32;
    localparam int POT_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int ERR_W      = POT_W + 1;
    localparam int DLT_W      = ERR_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    localparam logic [RATE_W-1:0]       RATE_RESET   = 16'd3277;
    localparam logic signed [THR_W-1:0] THRESH_RESET = 32'sd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECISION_THRESHOLD = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SAT,
        ST_OUT,
        ST_MUL,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic                    start;
        logic [RATE_W-1:0]       rate;
        logic signed [ERR_W-1:0] err;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic signed [DLT_W-1:0] delta;
    } t_mul_rsp;

endpackage

@@ src/lms_single_neuron_trainer_top.sv @@
// Single linear neuron trained by the LMS (Widrow-Hoff) rule.
// Input stream: s_axis_tdata carries the binary pattern and target class,
// s_axis_tuser the mode (0 classify, 1 classify and update weights).
// Output stream: m_axis_tdata carries the saturated Q16 potential, the
// decision (potential >= threshold) and the mismatch flag against the target.
// Configuration: i_cfg_we writes register i_cfg_idx (0 learning rate,
// 1 decision threshold) with i_cfg_data. The user must write only while
// the block is idle; the block itself does not enforce this.
// Timing: the weights are walked one per cycle; the sum is then saturated
// (ST_SAT) and loaded into the output register (ST_OUT) once it is free. A
// classify transaction then frees the input. A training transaction then runs
// the bit-serial rate multiplier (one rate bit per cycle) and walks the
// weights again for the update before it frees the input.
// The output register lets the update proceed while the result waits; a
// stalled receiver only holds the block once the next result is ready.
// Reset clears all weights to zero, restores the default rate and threshold,
// and empties the output register.
module lms_single_neuron_trainer_top
    import lmsnt_pkg::*;
#(
    parameter int NUM_INPUTS  = 20,
    parameter int WEIGHT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [19:0] pattern_bits, [20] target_class, [23:21] zero
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] potential, [32] decision, [33] mismatch, [39:34] zero
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W     = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int ACC_W     = WEIGHT_BITS + $clog2(NUM_INPUTS) + 1;
    localparam int EXT_W     = (ACC_W > POT_W + 1) ? ACC_W : POT_W + 1;
    localparam int UPD_W     = DLT_W + 1;
    localparam int PAT_EXT_W = (NUM_INPUTS > PAT_W) ? NUM_INPUTS : PAT_W;

    t_state                        r_state, n_state;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic [NUM_INPUTS-1:0]         r_pat, n_pat;
    logic                          r_mode, n_mode;
    logic                          r_tgt, n_tgt;
    logic signed [POT_W-1:0]       r_pot, n_pot;
    logic signed [DLT_W-1:0]       r_delta, n_delta;
    logic [RATE_W-1:0]             r_rate;
    logic signed [THR_W-1:0]       r_thr;
    logic signed [WEIGHT_BITS-1:0] r_weight [NUM_INPUTS];
    logic                          r_out_valid, n_out_valid;
    logic signed [POT_W-1:0]       r_out_pot;
    logic                          r_out_dec;
    logic                          r_out_mis;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_out_load;
    logic                          w_last;
    logic [PAT_EXT_W-1:0]          w_pat_ext;
    logic signed [WEIGHT_BITS-1:0] w_wsel;
    logic signed [EXT_W-1:0]       w_acc_ext;
    logic [EXT_W-POT_W:0]          w_acc_top;
    logic signed [POT_W-1:0]       w_pot_sat;
    logic                          w_dec;
    logic signed [UPD_W-1:0]       w_upd_sum;
    logic [UPD_W-WEIGHT_BITS:0]    w_upd_top;
    logic signed [WEIGHT_BITS-1:0] w_wnew;
    logic                          w_wr_en;
    t_mul_req                      w_mul_req;
    t_mul_rsp                      w_mul_rsp;

    lmsnt_ser_mul u_ser_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_out_load    = (r_state == ST_OUT) && w_out_free;
    assign w_last        = (r_idx == IDX_W'(NUM_INPUTS - 1));
    assign w_pat_ext     = PAT_EXT_W'(s_axis_tdata[PAT_W-1:0]);
    assign w_wsel        = r_weight[r_idx];

    // Clamp the wide sum to 32 bits
    always_comb begin
        w_acc_ext = EXT_W'(r_acc);
        w_acc_top = w_acc_ext[EXT_W-1:POT_W-1];
        if ((&w_acc_top) || !(|w_acc_top)) begin
            w_pot_sat = w_acc_ext[POT_W-1:0];
        end else if (w_acc_ext[EXT_W-1]) begin
            w_pot_sat = {1'b1, {(POT_W-1){1'b0}}};
        end else begin
            w_pot_sat = {1'b0, {(POT_W-1){1'b1}}};
        end
    end

    // Clamp the updated weight to its signed range
    always_comb begin
        w_upd_sum = UPD_W'(w_wsel) + UPD_W'(r_delta);
        w_upd_top = w_upd_sum[UPD_W-1:WEIGHT_BITS-1];
        if ((&w_upd_top) || !(|w_upd_top)) begin
            w_wnew = w_upd_sum[WEIGHT_BITS-1:0];
        end else if (w_upd_sum[UPD_W-1]) begin
            w_wnew = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
        end else begin
            w_wnew = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
        end
    end

    assign w_dec   = (r_pot >= r_thr);
    assign w_wr_en = (r_state == ST_UPD) && r_pat[r_idx];

    // Error term tgt * 1.0 - potential, handed to the multiplier on the result cycle
    assign w_mul_req.start = w_out_load && r_mode;
    assign w_mul_req.rate  = r_rate;
    assign w_mul_req.err   = ERR_W'($signed({1'b0, r_tgt, {FRAC_W{1'b0}}})) - ERR_W'(r_pot);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_pat       = r_pat;
        n_mode      = r_mode;
        n_tgt       = r_tgt;
        n_pot       = r_pot;
        n_delta     = r_delta;
        n_out_valid = r_out_valid;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_pat   = w_pat_ext[NUM_INPUTS-1:0];
                    n_mode  = s_axis_tuser[0];
                    n_tgt   = s_axis_tdata[PAT_W];
                    n_acc   = '0;
                    n_idx   = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_pat[r_idx]) begin
                    n_acc = r_acc + ACC_W'(w_wsel);
                end
                n_idx = r_idx + 1'b1;
                if (w_last) begin
                    n_idx   = '0;
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                n_pot   = w_pot_sat;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = r_mode ? ST_MUL : ST_IDLE;
                end
            end
            ST_MUL: begin
                if (w_mul_rsp.done) begin
                    n_delta = w_mul_rsp.delta;
                    n_idx   = '0;
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_idx = r_idx + 1'b1;
                if (w_last) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_pat   <= n_pat;
        r_mode  <= n_mode;
        r_tgt   <= n_tgt;
        r_pot   <= n_pot;
        r_delta <= n_delta;
        if (w_out_load) begin
            r_out_pot <= r_pot;
            r_out_dec <= w_dec;
            r_out_mis <= w_dec ^ r_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_INPUTS; i++) begin
                r_weight[i] <= '0;
            end
        end else if (w_wr_en) begin
            r_weight[r_idx] <= w_wnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_thr  <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEARNING_RATE:      r_rate <= i_cfg_data[RATE_W-1:0];
                CFG_DECISION_THRESHOLD: r_thr  <= $signed(i_cfg_data[THR_W-1:0]);
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-POT_W-2){1'b0}}, r_out_mis, r_out_dec, r_out_pot};

`ifndef NO_ASSERTIONS
    a_accept_clears_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SUM) && (r_acc == '0) && (r_idx == '0))
        else $error("accepted transaction did not start a fresh sum");

    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == ST_MUL))
        else $error("multiplier finished outside its wait state");

    a_classify_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && !r_mode) |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("classify transaction did not finish after its result");

    a_train_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_mode) |=> (r_state == ST_MUL))
        else $error("training transaction skipped the multiply");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid && $stable(r_out_pot))
        else $error("waiting result overwritten");
`endif

endmodule

@@ src/lmsnt_ser_mul.sv @@
module lmsnt_ser_mul
    import lmsnt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int CNT_W = $clog2(RATE_W);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [RATE_W-1:0]       r_rate, n_rate;
    logic signed [ERR_W-1:0] r_mcand, n_mcand;
    logic signed [DLT_W-1:0] r_hi, n_hi;
    logic [RATE_W-1:0]       r_lo, n_lo;
    logic signed [DLT_W-1:0] w_sum;

    // One multiplier bit a cycle, LSB first; low product bits shift out into r_lo
    always_comb begin
        w_sum   = r_hi + (r_rate[0] ? $signed({r_mcand[ERR_W-1], r_mcand}) : '0);
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rate  = r_rate;
        n_mcand = r_mcand;
        n_hi    = r_hi;
        n_lo    = r_lo;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_rate  = i_req.rate;
            n_mcand = i_req.err;
            n_hi    = '0;
            n_lo    = '0;
        end else if (r_busy) begin
            n_hi   = w_sum >>> 1;
            n_lo   = {w_sum[0], r_lo[RATE_W-1:1]};
            n_rate = {1'b0, r_rate[RATE_W-1:1]};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(RATE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate  <= n_rate;
        r_mcand <= n_mcand;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
    end

    // Round half up: adding one half of the dropped fraction carries iff its top bit is set
    assign o_rsp.done  = r_done;
    assign o_rsp.delta = r_hi + $signed({{(DLT_W-1){1'b0}}, r_lo[RATE_W-1]});

endmodule
